// ===== hdl/cmos_rtc_index_data_ports_unit_macros.svh =====
// ----------------------------------------------------------------------------
// CMOS RTC port unit assertion macros
// Immediate-implication and next-cycle assertion helpers clocked on clk.
// ----------------------------------------------------------------------------
`ifndef CMOS_RTC_INDEX_DATA_PORTS_UNIT_MACROS_SVH
`define CMOS_RTC_INDEX_DATA_PORTS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CRTC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crtc assertion failed");
`define CRTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crtc assertion failed");
`else
`define CRTC_ASSERT_IMPLIES(label, ante, cons)
`define CRTC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/crtc_pkg.sv =====
// ----------------------------------------------------------------------------
// CMOS RTC package
// Store geometry, action codes, register addresses and word types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package crtc_pkg;
  localparam int STORE_DEPTH = 128;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int TICK_W = 15;

  localparam logic [2:0] ACT_WR_INDEX = 3'd0;
  localparam logic [2:0] ACT_RD_INDEX = 3'd1;
  localparam logic [2:0] ACT_WR_DATA  = 3'd2;
  localparam logic [2:0] ACT_RD_DATA  = 3'd3;
  localparam logic [2:0] ACT_TICK     = 3'd4;

  localparam logic [6:0] REG_A = 7'h0A;
  localparam logic [6:0] REG_B = 7'h0B;
  localparam int PIE_BIT = 6;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] write_value;
  } item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       periodic_irq;
    logic       nmi_masked;
  } result_t;

  typedef struct packed {
    logic       tick;
    logic       wr_en;
    logic [6:0] wr_index;
    logic [7:0] wr_data;
  } timer_ctrl_t;
endpackage

// ===== hdl/cmos_rtc_index_data_ports_unit.sv =====
// ----------------------------------------------------------------------------
// CMOS RTC index/data port unit
// Index register, NMI mask, 128-byte CMOS store and periodic interrupt.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Word
//  input     start / busy       item   (action, write_value)
//  output    strobe             result (read_value, periodic_irq, nmi_masked)
//
//  A word is taken in any cycle with start high and busy low, one per cycle.
//  Its result shows on result with strobe high in the following cycle only.
//  The store read port is registered, which sets that delay.
//  Reset clears the index, mask, timer and per-entry valid bits at once.
//  Busy is high only during reset; results cannot be stalled.
`timescale 1ns / 1ps
`include "cmos_rtc_index_data_ports_unit_macros.svh"
module cmos_rtc_index_data_ports_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  crtc_pkg::item_t   item,
  output logic              strobe,
  output crtc_pkg::result_t result
);
  import crtc_pkg::*;

  localparam logic [7:0] DEPTH_B = 8'(STORE_DEPTH);

  logic              accept;
  logic [6:0]        reg_index;
  logic              nmi_mask;
  logic [STORE_DEPTH-1:0] valid;
  logic [ADDR_W-1:0] addr;
  logic              in_range;
  logic              data_we;
  logic [7:0]        rdata;
  logic              rd_valid;
  logic [2:0]        act_q;
  logic [7:0]        index_word;
  logic              irq_q;
  logic              irq;
  timer_ctrl_t       tctrl;

  assign busy = rst;
  assign accept = start && !busy;
  assign addr = reg_index[ADDR_W-1:0];
  assign in_range = {1'b0, reg_index} < DEPTH_B;
  assign data_we = accept && item.action == ACT_WR_DATA && in_range;

  assign tctrl.tick = accept && item.action == ACT_TICK;
  assign tctrl.wr_en = data_we;
  assign tctrl.wr_index = reg_index;
  assign tctrl.wr_data = item.write_value;

  crtc_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (data_we),
    .addr  (addr),
    .wdata (item.write_value),
    .rdata (rdata)
  );

  crtc_timer u_timer (
    .clk  (clk),
    .rst  (rst),
    .ctrl (tctrl),
    .irq  (irq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_index <= '0;
      nmi_mask <= 1'b0;
      valid <= '0;
      strobe <= 1'b0;
      act_q <= ACT_WR_INDEX;
    end else begin
      strobe <= accept;
      if (accept) begin
        act_q <= item.action;
        if (item.action == ACT_WR_INDEX) begin
          reg_index <= item.write_value[6:0];
          nmi_mask <= item.write_value[7];
        end
      end
      if (data_we) begin
        valid[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_valid <= in_range && valid[addr];
      index_word <= {nmi_mask, reg_index};
      irq_q <= irq && item.action == ACT_TICK;
    end
  end

  always_comb begin
    result.periodic_irq = strobe && irq_q;
    result.nmi_masked = nmi_mask;
    case (act_q)
      ACT_RD_INDEX: result.read_value = index_word;
      ACT_RD_DATA:  result.read_value = rd_valid ? rdata : 8'h00;
      default:      result.read_value = 8'h00;
    endcase
  end

  `CRTC_ASSERT_NEXT(a_strobe_follows_accept, accept, strobe)
  `CRTC_ASSERT_NEXT(a_no_spurious_strobe, !accept, !strobe)
  `CRTC_ASSERT_IMPLIES(a_irq_only_on_tick, strobe && result.periodic_irq, act_q == ACT_TICK)
  `CRTC_ASSERT_IMPLIES(a_index_read_mask, strobe && act_q == ACT_RD_INDEX,
                       result.read_value[7] == result.nmi_masked)
endmodule

// ===== hdl/crtc_ram.sv =====
// ----------------------------------------------------------------------------
// CMOS RTC generic RAM
// Single-address synchronous RAM with a registered, read-first read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module crtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/crtc_timer.sv =====
// ----------------------------------------------------------------------------
// CMOS RTC periodic timer
// Shadows the rate and enable bits and divides the timebase ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module crtc_timer (
  input  logic                 clk,
  input  logic                 rst,
  input  crtc_pkg::timer_ctrl_t ctrl,
  output logic                 irq
);
  import crtc_pkg::*;

  logic [3:0]        rate;
  logic              pie;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] tick_count_next;
  logic [TICK_W-1:0] count_inc;
  logic [TICK_W-1:0] period;
  logic              enabled;

  assign enabled = pie && (rate != 4'd0);
  assign count_inc = tick_count + TICK_W'(1);
  assign period = TICK_W'(1) << (rate - 4'd1);
  assign irq = enabled && (count_inc >= period);

  always_comb begin
    tick_count_next = tick_count;
    if (ctrl.tick) begin
      if (!enabled || irq) begin
        tick_count_next = '0;
      end else begin
        tick_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= '0;
      pie <= 1'b0;
      tick_count <= '0;
    end else begin
      tick_count <= tick_count_next;
      if (ctrl.wr_en && ctrl.wr_index == REG_A) begin
        rate <= ctrl.wr_data[3:0];
      end
      if (ctrl.wr_en && ctrl.wr_index == REG_B) begin
        pie <= ctrl.wr_data[PIE_BIT];
      end
    end
  end
endmodule
